[src/abbd_pkg.sv]
// Shared types, constants and helpers for the arcade board bus decoder.
`default_nettype none
package abbd_pkg;

   localparam int unsigned ROM_DEPTH   = 16384;
   localparam int unsigned RAM_DEPTH   = 1024;
   localparam int unsigned OBJ_DEPTH   = 256;
   localparam int unsigned VIDEO_DEPTH = 1024;

   localparam int unsigned ROM_AW   = $clog2(ROM_DEPTH);
   localparam int unsigned RAM_AW   = $clog2(RAM_DEPTH);
   localparam int unsigned OBJ_AW   = $clog2(OBJ_DEPTH);
   localparam int unsigned VIDEO_AW = $clog2(VIDEO_DEPTH);

   localparam int unsigned CLEAR_DEPTH_A = (RAM_DEPTH > VIDEO_DEPTH) ? RAM_DEPTH : VIDEO_DEPTH;
   localparam int unsigned CLEAR_DEPTH   =
      (CLEAR_DEPTH_A > OBJ_DEPTH) ? CLEAR_DEPTH_A : OBJ_DEPTH;
   localparam int unsigned CLEAR_AW      = $clog2(CLEAR_DEPTH);

   localparam int unsigned CSR_AW = 3;

   // operation codes
   localparam logic [2:0] OP_READ  = 3'd0;
   localparam logic [2:0] OP_WRITE = 3'd1;
   localparam logic [2:0] OP_LOAD  = 3'd2;
   localparam logic [2:0] OP_FRAME = 3'd3;
   localparam logic [2:0] OP_POLL  = 3'd4;

   // board profiles
   localparam logic [1:0] PROF_BASE = 2'd0;
   localparam logic [1:0] PROF_ALT  = 2'd1;
   localparam logic [1:0] PROF_BANK = 2'd2;

   // configuration register indexes
   localparam logic REG_PROFILE = 1'b0;
   localparam logic REG_DIP     = 1'b1;

   // sound targets
   localparam logic [1:0] SND_LFO   = 2'd0;
   localparam logic [1:0] SND_LATCH = 2'd1;
   localparam logic [1:0] SND_PITCH = 2'd2;

   // 2 KB regions above the map base
   localparam logic [2:0] RGN_WORK  = 3'd0;
   localparam logic [2:0] RGN_HOLE  = 3'd1;
   localparam logic [2:0] RGN_VIDEO = 3'd2;
   localparam logic [2:0] RGN_OBJ   = 3'd3;
   localparam logic [2:0] RGN_PORT0 = 3'd4;
   localparam logic [2:0] RGN_PORT1 = 3'd5;
   localparam logic [2:0] RGN_CTRL  = 3'd6;
   localparam logic [2:0] RGN_PITCH = 3'd7;

   localparam logic [15:0] ROM_TOP   = 16'h4000;
   localparam logic [15:0] BASE_STD  = 16'h4000;
   localparam logic [15:0] BASE_ALT  = 16'h8000;
   localparam logic [15:0] MAP_SPAN  = 16'h4000;
   localparam logic [7:0]  BYTE_NONE = 8'hff;
   localparam logic [7:0]  FLIP_HI   = 8'h40;
   localparam logic [7:0]  FLIP_LO   = 8'h04;

   typedef enum logic [2:0] {
      SRC_CONST = 3'd0,
      SRC_ROM   = 3'd1,
      SRC_WORK  = 3'd2,
      SRC_VIDEO = 3'd3,
      SRC_OBJ   = 3'd4
   } src_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] bus_address;
      logic [7:0]  bus_data;
      logic [7:0]  port_zero_pins;
      logic [7:0]  port_one_pins;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       sound_valid;
      logic [1:0] sound_target;
      logic [2:0] sound_register;
      logic [7:0] sound_value;
      logic       nmi_request;
      logic       stars_on;
      logic       mirror_x;
      logic       mirror_y;
      logic [2:0] graphics_bank;
   } rsp_payload_type;

   function automatic logic [7:0] descramble(input logic [7:0] raw, input logic even);
      logic [7:0] r;
      logic       b6;
      r = raw;
      if (raw[1]) begin
         r = r ^ FLIP_HI;
      end
      if (raw[5]) begin
         r = r ^ FLIP_LO;
      end
      if (even) begin
         b6   = r[6];
         r[6] = r[2];
         r[2] = b6;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[src/abbd_if.sv]
// Valid/ready channel interfaces for bus items and results.
`default_nettype none
interface abbd_req_if;
   logic                      valid;
   logic                      ready;
   abbd_pkg::req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface abbd_rsp_if;
   logic                      valid;
   logic                      ready;
   abbd_pkg::rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[src/arcade_board_bus_decoder_core.sv]
// Arcade board bus decoder: memory map, ROM descramble, latches and NMI logic.
// Stages: s1_ff with the single-port memory read registers, then output register rsp_ff.
// Throughput: one item per cycle unless stalled; each item makes at most one memory access.
// Reset: synchronous; profile = alternate, DIP = 0, latches and NMI state cleared.
// After reset, work/video/object RAM are zero-filled with req_bus.ready low, over
// max(RAM_DEPTH, VIDEO_DEPTH, OBJ_DEPTH) addresses; program ROM is not cleared.
`default_nettype none
module arcade_board_bus_decoder_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   abbd_req_if.sink                         req_bus,
   abbd_rsp_if.source                       rsp_bus,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [abbd_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]                 csr_pwdata,
   output logic      [31:0]                 csr_prdata,
   output logic                             csr_pready
);

   typedef struct packed {
      abbd_pkg::src_type         src;
      abbd_pkg::rsp_payload_type rsp;
   } s1_type;

   logic [7:0] rom_mem   [abbd_pkg::ROM_DEPTH];
   logic [7:0] work_mem  [abbd_pkg::RAM_DEPTH];
   logic [7:0] video_mem [abbd_pkg::VIDEO_DEPTH];
   logic [7:0] obj_mem   [abbd_pkg::OBJ_DEPTH];

   logic [7:0] rom_q_ff, work_q_ff, video_q_ff, obj_q_ff;

   logic [1:0] profile_ff;
   logic [7:0] dip_ff;
   logic [2:0] bank_ff, bank_in;
   logic [2:0] disp_ff, disp_in;
   logic       nmi_en_ff, nmi_en_in;
   logic       nmi_pend_ff, nmi_pend_in;

   logic                         clear_ff, clear_in;
   logic [abbd_pkg::CLEAR_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic                         clr_last;

   logic   s1_valid_ff, s1_valid_in;
   s1_type s1_ff, s1_in;
   logic   rsp_valid_ff, rsp_valid_in;
   abbd_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic out_free, s1_adv, accept, cfg_we;

   logic        alt, mapped;
   logic [15:0] addr, base, rel;
   logic [2:0]  rgn, off;
   logic [7:0]  wdata;

   logic                          rom_we, rom_re;
   logic [abbd_pkg::ROM_AW-1:0]   rom_addr;
   logic [7:0]                    rom_wd;
   logic                          work_we, work_re;
   logic [abbd_pkg::RAM_AW-1:0]   work_addr;
   logic                          video_we, video_re;
   logic [abbd_pkg::VIDEO_AW-1:0] video_addr;
   logic                          obj_we, obj_re;
   logic [abbd_pkg::OBJ_AW-1:0]   obj_addr;
   logic [7:0]                    ram_wd;

   // handshake
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign s1_adv        = s1_valid_ff && out_free;
   assign req_bus.ready = !clear_ff && (!s1_valid_ff || out_free);
   assign accept        = req_bus.valid && req_bus.ready;
   assign s1_valid_in   = accept || (s1_valid_ff && !out_free);
   assign rsp_valid_in  = s1_adv || (rsp_valid_ff && !rsp_bus.ready);

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;

   // configuration
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_paddr[2])
         abbd_pkg::REG_PROFILE: csr_prdata = {30'd0, profile_ff};
         abbd_pkg::REG_DIP:     csr_prdata = {24'd0, dip_ff};
         default:               csr_prdata = 32'd0;
      endcase
   end

   // clearing pass
   assign clr_last   = clr_cnt_ff == abbd_pkg::CLEAR_AW'(abbd_pkg::CLEAR_DEPTH - 1);
   assign clr_cnt_in = clr_cnt_ff + 1'b1;
   assign clear_in   = clear_ff && !clr_last;

   // decode
   always_comb begin
      addr   = req_bus.payload.bus_address;
      wdata  = req_bus.payload.bus_data;
      alt    = profile_ff == abbd_pkg::PROF_ALT;
      base   = alt ? abbd_pkg::BASE_ALT : abbd_pkg::BASE_STD;
      rel    = addr - base;
      mapped = (addr >= base) && (rel < abbd_pkg::MAP_SPAN);
      rgn    = rel[13:11];
      off    = addr[2:0];

      bank_in     = bank_ff;
      disp_in     = disp_ff;
      nmi_en_in   = nmi_en_ff;
      nmi_pend_in = nmi_pend_ff;

      s1_in     = '0;
      s1_in.src = abbd_pkg::SRC_CONST;
      s1_in.rsp.read_data = abbd_pkg::BYTE_NONE;

      rom_we   = 1'b0;
      rom_re   = 1'b0;
      rom_addr = abbd_pkg::ROM_AW'(addr);
      rom_wd   = alt ? abbd_pkg::descramble(wdata, !addr[0]) : wdata;
      work_we  = 1'b0;
      work_re  = 1'b0;
      video_we = 1'b0;
      video_re = 1'b0;
      obj_we   = 1'b0;
      obj_re   = 1'b0;
      work_addr  = abbd_pkg::RAM_AW'(32'(rel[9:0]) % abbd_pkg::RAM_DEPTH);
      video_addr = abbd_pkg::VIDEO_AW'(rel[9:0]);
      obj_addr   = abbd_pkg::OBJ_AW'(32'(rel[7:0]) % abbd_pkg::OBJ_DEPTH);
      ram_wd     = wdata;

      if (accept) begin
         case (req_bus.payload.op)
            abbd_pkg::OP_READ: begin
               if (addr < abbd_pkg::ROM_TOP) begin
                  if (32'(addr) < abbd_pkg::ROM_DEPTH) begin
                     rom_re    = 1'b1;
                     s1_in.src = abbd_pkg::SRC_ROM;
                  end
               end else if (mapped) begin
                  unique case (rgn)
                     abbd_pkg::RGN_WORK: begin
                        work_re   = 1'b1;
                        s1_in.src = abbd_pkg::SRC_WORK;
                     end
                     abbd_pkg::RGN_VIDEO: begin
                        video_re  = 1'b1;
                        s1_in.src = abbd_pkg::SRC_VIDEO;
                     end
                     abbd_pkg::RGN_OBJ: begin
                        obj_re    = 1'b1;
                        s1_in.src = abbd_pkg::SRC_OBJ;
                     end
                     abbd_pkg::RGN_PORT0: s1_in.rsp.read_data = req_bus.payload.port_zero_pins;
                     abbd_pkg::RGN_PORT1: s1_in.rsp.read_data = req_bus.payload.port_one_pins;
                     abbd_pkg::RGN_CTRL:  s1_in.rsp.read_data = dip_ff;
                     default:             s1_in.rsp.read_data = abbd_pkg::BYTE_NONE;
                  endcase
               end
            end
            abbd_pkg::OP_WRITE: begin
               if (mapped) begin
                  unique case (rgn)
                     abbd_pkg::RGN_WORK:  work_we  = 1'b1;
                     abbd_pkg::RGN_VIDEO: video_we = 1'b1;
                     abbd_pkg::RGN_OBJ:   obj_we   = 1'b1;
                     abbd_pkg::RGN_PORT0: begin
                        if (off[2]) begin
                           s1_in.rsp.sound_valid    = 1'b1;
                           s1_in.rsp.sound_target   = abbd_pkg::SND_LFO;
                           s1_in.rsp.sound_register = {1'b0, off[1:0]};
                           s1_in.rsp.sound_value    = wdata;
                        end else if (alt) begin
                           if (off[1:0] != 2'd3) begin
                              bank_in[off[1:0]] = wdata[0];
                           end
                        end else if (profile_ff == abbd_pkg::PROF_BANK && off == 3'd2) begin
                           bank_in[0] = wdata[0];
                        end
                     end
                     abbd_pkg::RGN_PORT1: begin
                        s1_in.rsp.sound_valid    = 1'b1;
                        s1_in.rsp.sound_target   = abbd_pkg::SND_LATCH;
                        s1_in.rsp.sound_register = off;
                        s1_in.rsp.sound_value    = wdata;
                     end
                     abbd_pkg::RGN_CTRL: begin
                        if (off == (alt ? 3'd0 : 3'd1)) begin
                           nmi_en_in = wdata[0];
                        end else if (off == 3'd4) begin
                           disp_in[0] = wdata[0];
                        end else if (off == 3'd6) begin
                           disp_in[1] = wdata[0];
                        end else if (off == 3'd7) begin
                           disp_in[2] = wdata[0];
                        end
                     end
                     abbd_pkg::RGN_PITCH: begin
                        s1_in.rsp.sound_valid  = 1'b1;
                        s1_in.rsp.sound_target = abbd_pkg::SND_PITCH;
                        s1_in.rsp.sound_value  = wdata;
                     end
                     default: ;
                  endcase
               end
            end
            abbd_pkg::OP_LOAD: begin
               rom_we = 32'(addr) < abbd_pkg::ROM_DEPTH;
            end
            abbd_pkg::OP_FRAME: begin
               nmi_pend_in = nmi_en_ff;
            end
            abbd_pkg::OP_POLL: begin
               if (nmi_pend_ff) begin
                  s1_in.rsp.nmi_request = 1'b1;
                  nmi_pend_in           = 1'b0;
               end
            end
            default: ;
         endcase
      end

      s1_in.rsp.stars_on      = disp_in[0];
      s1_in.rsp.mirror_x      = disp_in[1];
      s1_in.rsp.mirror_y      = disp_in[2];
      s1_in.rsp.graphics_bank = bank_in;

      if (clear_ff) begin
         work_we    = 1'b1;
         video_we   = 1'b1;
         obj_we     = 1'b1;
         work_addr  = abbd_pkg::RAM_AW'(clr_cnt_ff);
         video_addr = abbd_pkg::VIDEO_AW'(clr_cnt_ff);
         obj_addr   = abbd_pkg::OBJ_AW'(clr_cnt_ff);
         ram_wd     = 8'd0;
      end
   end

   // result select after memory read
   always_comb begin
      rsp_in = s1_ff.rsp;
      case (s1_ff.src)
         abbd_pkg::SRC_ROM:   rsp_in.read_data = rom_q_ff;
         abbd_pkg::SRC_WORK:  rsp_in.read_data = work_q_ff;
         abbd_pkg::SRC_VIDEO: rsp_in.read_data = video_q_ff;
         abbd_pkg::SRC_OBJ:   rsp_in.read_data = obj_q_ff;
         default:             rsp_in.read_data = s1_ff.rsp.read_data;
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (rom_we) begin
         rom_mem[rom_addr] <= rom_wd;
      end
      if (rom_re) begin
         rom_q_ff <= rom_mem[rom_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (work_we) begin
         work_mem[work_addr] <= ram_wd;
      end
      if (work_re) begin
         work_q_ff <= work_mem[work_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (video_we) begin
         video_mem[video_addr] <= ram_wd;
      end
      if (video_re) begin
         video_q_ff <= video_mem[video_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (obj_we) begin
         obj_mem[obj_addr] <= ram_wd;
      end
      if (obj_re) begin
         obj_q_ff <= obj_mem[obj_addr];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         profile_ff   <= abbd_pkg::PROF_ALT;
         dip_ff       <= 8'd0;
         bank_ff      <= 3'd0;
         disp_ff      <= 3'd0;
         nmi_en_ff    <= 1'b0;
         nmi_pend_ff  <= 1'b0;
         clear_ff     <= 1'b1;
         clr_cnt_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_we) begin
            unique case (csr_paddr[2])
               abbd_pkg::REG_PROFILE: profile_ff <= csr_pwdata[1:0];
               abbd_pkg::REG_DIP:     dip_ff     <= csr_pwdata[7:0];
               default: ;
            endcase
         end
         bank_ff      <= bank_in;
         disp_ff      <= disp_in;
         nmi_en_ff    <= nmi_en_in;
         nmi_pend_ff  <= nmi_pend_in;
         clear_ff     <= clear_in;
         if (clear_ff) begin
            clr_cnt_ff <= clr_cnt_in;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   // checks
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !req_bus.ready)
      else $error("transfer accepted during RAM clear");

   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item lost before memory stage");

   a_poll_clears_pending: assert property (@(posedge clock) disable iff (reset)
      (accept && req_bus.payload.op == abbd_pkg::OP_POLL && nmi_pend_ff)
      |=> (!nmi_pend_ff && s1_ff.rsp.nmi_request))
      else $error("nmi poll did not consume pending request");

   a_sound_only_on_write: assert property (@(posedge clock) disable iff (reset)
      (accept && req_bus.payload.op != abbd_pkg::OP_WRITE) |=> !s1_ff.rsp.sound_valid)
      else $error("sound transfer flagged for non-write item");

   a_s1_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_ff)))
      else $error("memory stage changed while output stalled");

endmodule
`default_nettype wire
